### rtl/lqp_pkg.sv
// Shared types and filter arithmetic for the luma quarter-pel interpolator.
package lqp_pkg;

  typedef logic [5:0][7:0] pcol_t;
  typedef logic [4:0][7:0] pline_t;
  typedef logic signed [14:0] hsum_t;
  typedef logic [5:0][14:0] hcol_t;
  typedef logic [4:0][14:0] hline_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] fx;
    logic [1:0] fy;
    logic       last;
    pcol_t      col_a;
    pcol_t      col_b;
    hcol_t      hs;
  } tap_bus_t;

  function automatic hsum_t tap6_pix(input pcol_t p);
    logic signed [14:0] a0, a1, a2, a3, a4, a5;
    a0 = $signed({7'd0, p[0]});
    a1 = $signed({7'd0, p[1]});
    a2 = $signed({7'd0, p[2]});
    a3 = $signed({7'd0, p[3]});
    a4 = $signed({7'd0, p[4]});
    a5 = $signed({7'd0, p[5]});
    return a0 - 15'sd5 * a1 + 15'sd20 * a2 + 15'sd20 * a3 - 15'sd5 * a4 + a5;
  endfunction

  function automatic logic signed [20:0] tap6_hs(input hcol_t h);
    logic signed [20:0] a0, a1, a2, a3, a4, a5;
    a0 = 21'($signed(h[0]));
    a1 = 21'($signed(h[1]));
    a2 = 21'($signed(h[2]));
    a3 = 21'($signed(h[3]));
    a4 = 21'($signed(h[4]));
    a5 = 21'($signed(h[5]));
    return a0 - 21'sd5 * a1 + 21'sd20 * a2 + 21'sd20 * a3 - 21'sd5 * a4 + a5;
  endfunction

  // (s + 16) >> 5, clipped to 0..255
  function automatic logic [7:0] clip_half(input hsum_t s);
    logic signed [15:0] t;
    t = 16'($signed(s)) + 16'sd16;
    if (t < 0) return 8'd0;
    if (t[15:5] > 11'd255) return 8'd255;
    return t[12:5];
  endfunction

  // (s + 512) >> 10, clipped to 0..255
  function automatic logic [7:0] clip_ctr(input logic signed [20:0] s);
    logic signed [21:0] t;
    t = 22'($signed(s)) + 22'sd512;
    if (t < 0) return 8'd0;
    if (t[21:10] > 12'd255) return 8'd255;
    return t[17:10];
  endfunction

  function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, a} + {1'b0, b} + 9'd1;
    return t[8:1];
  endfunction

endpackage

### rtl/lqp_window.sv
// Window position tracking, row shift and column line memories.
module lqp_window import lqp_pkg::*; #(
  parameter int MAX_BLOCK = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       accept,
  input  logic [7:0] window_pixel,
  input  logic       block_start,
  input  logic [1:0] frac_x,
  input  logic [1:0] frac_y,
  input  logic [4:0] block_w,
  input  logic [4:0] block_h,
  output tap_bus_t   taps
);

  localparam int LINE_W = MAX_BLOCK + 5;
  localparam int CW = $clog2(LINE_W + 1);
  localparam int PAW = $clog2(LINE_W);
  localparam int HAW = $clog2(MAX_BLOCK);

  logic [1:0]    lat_fx, lat_fy;
  logic [CW-1:0] lat_w, lat_h;
  logic [CW-1:0] col, row;
  pcol_t         rs;

  logic [1:0]    fx_e, fy_e;
  logic [CW-1:0] w_e, h_e, ww, wh, col_e, row_e, col_n, row_n;
  pcol_t         rs_n;
  hsum_t         hsum;
  logic          emit, last, hwr;

  function automatic logic [CW-1:0] clamp(input logic [4:0] raw);
    if (raw == 5'd0) return CW'(1);
    if (32'(raw) > MAX_BLOCK) return CW'(MAX_BLOCK);
    return raw[CW-1:0];
  endfunction

  always_comb begin
    fx_e = block_start ? frac_x : lat_fx;
    fy_e = block_start ? frac_y : lat_fy;
    w_e  = block_start ? clamp(block_w) : lat_w;
    h_e  = block_start ? clamp(block_h) : lat_h;
    ww   = w_e + CW'(5);
    wh   = h_e + CW'(5);
    if (block_start || col >= ww || row >= wh) begin
      col_e = '0;
      row_e = '0;
    end else begin
      col_e = col;
      row_e = row;
    end
    rs_n = {window_pixel, rs[5:1]};
    hsum = tap6_pix(rs_n);
    hwr  = col_e >= CW'(5);
    emit = hwr && row_e >= CW'(5);
    last = col_e == ww - CW'(1) && row_e == wh - CW'(1);
    if (col_e == ww - CW'(1)) begin
      col_n = '0;
      row_n = (row_e == wh - CW'(1)) ? '0 : row_e + CW'(1);
    end else begin
      col_n = col_e + CW'(1);
      row_n = row_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_fx <= '0;
      lat_fy <= '0;
      lat_w  <= CW'(1);
      lat_h  <= CW'(1);
      col    <= '0;
      row    <= '0;
      rs     <= '0;
    end else if (accept) begin
      lat_fx <= fx_e;
      lat_fy <= fy_e;
      lat_w  <= w_e;
      lat_h  <= h_e;
      col    <= col_n;
      row    <= row_n;
      rs     <= rs_n;
    end
  end

  // read stage
  pline_t         pix_mem [LINE_W];
  hline_t         hs_mem [MAX_BLOCK];
  pline_t         pix_rd, fwd_data;
  hline_t         hs_rd;
  logic           fwd;
  logic           s1_valid, s1_emit, s1_last, s1_hwr;
  logic [1:0]     s1_fx, s1_fy;
  logic [PAW-1:0] s1_col;
  logic [HAW-1:0] s1_hidx;
  logic [7:0]     s1_px;
  hsum_t          s1_hs;
  pcol_t          vec, cv1, cv2, cv3;
  hcol_t          hvec;
  logic [CW-1:0]  hidx_e;

  assign hidx_e = col_e - CW'(5);

  always_comb begin
    vec  = {s1_px, (fwd ? fwd_data : pix_rd)};
    hvec = {s1_hs, hs_rd};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_rd <= pix_mem[col_e[PAW-1:0]];
      if (hwr) hs_rd <= hs_mem[hidx_e[HAW-1:0]];
    end
    if (en) begin
      fwd      <= accept && s1_valid && s1_col == col_e[PAW-1:0];
      fwd_data <= vec[5:1];
      s1_col   <= col_e[PAW-1:0];
      s1_hidx  <= hidx_e[HAW-1:0];
      s1_px    <= window_pixel;
      s1_hs    <= hsum;
      s1_emit  <= emit;
      s1_last  <= last;
      s1_hwr   <= hwr;
      s1_fx    <= fx_e;
      s1_fy    <= fy_e;
    end
    if (en && s1_valid) begin
      pix_mem[s1_col] <= vec[5:1];
      if (s1_hwr) hs_mem[s1_hidx] <= hvec[5:1];
      cv1 <= vec;
      cv2 <= cv1;
      cv3 <= cv2;
      taps.col_a <= cv3;
      taps.col_b <= cv2;
      taps.hs    <= hvec;
      taps.fx    <= s1_fx;
      taps.fy    <= s1_fy;
      taps.last  <= s1_last;
    end
    if (rst) begin
      s1_valid   <= 1'b0;
      taps.valid <= 1'b0;
    end else if (en) begin
      s1_valid   <= accept;
      taps.valid <= s1_valid && s1_emit;
    end
  end

endmodule

### rtl/lqp_filter.sv
// Six-tap half samples, centre sample, phase select and output register.
module lqp_filter import lqp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  tap_bus_t   taps,
  output logic       out_valid,
  output logic [7:0] pred_pixel,
  output logic       block_end
);

  logic       h_valid, h_last;
  logic [1:0] h_fx, h_fy;
  logic [7:0] g, g_dn, g_rt, b2, b3, hva, hvb, jj;
  logic [7:0] v, vcol, brow;

  always_ff @(posedge clk) begin
    if (en) begin
      h_fx   <= taps.fx;
      h_fy   <= taps.fy;
      h_last <= taps.last;
      g      <= taps.col_a[2];
      g_dn   <= taps.col_a[3];
      g_rt   <= taps.col_b[2];
      b2     <= clip_half($signed(taps.hs[2]));
      b3     <= clip_half($signed(taps.hs[3]));
      hva    <= clip_half(tap6_pix(taps.col_a));
      hvb    <= clip_half(tap6_pix(taps.col_b));
      jj     <= clip_ctr(tap6_hs(taps.hs));
    end
  end

  always_comb begin
    vcol = (h_fx == 2'd1) ? hva : hvb;
    brow = (h_fy == 2'd1) ? b2 : b3;
    if (h_fx == 2'd0 && h_fy == 2'd0) begin
      v = g;
    end else if (h_fy == 2'd0) begin
      v = (h_fx == 2'd2) ? b2 : avg2((h_fx == 2'd1) ? g : g_rt, b2);
    end else if (h_fx == 2'd0) begin
      v = (h_fy == 2'd2) ? hva : avg2((h_fy == 2'd1) ? g : g_dn, hva);
    end else if (h_fx == 2'd2 && h_fy == 2'd2) begin
      v = jj;
    end else if (h_fy == 2'd2) begin
      v = avg2(vcol, jj);
    end else if (h_fx == 2'd2) begin
      v = avg2(brow, jj);
    end else begin
      v = avg2(brow, vcol);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pred_pixel <= v;
      block_end  <= h_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      h_valid   <= taps.valid;
      out_valid <= h_valid;
    end
  end

endmodule

### rtl/luma_quarter_pel_interpolator.sv
// Top level of the streaming H.264 luma quarter-pel interpolator.
//  channel | direction | fields (tdata low bit up; tuser; tlast)
//  s_*     | in        | tdata: window_pixel, frac_x, frac_y, block_w, block_h; tuser: block_start
//  m_*     | out       | tdata: pred_pixel; tlast: block_end
// One window pixel per cycle while the output is not stalled; a predicted pixel is valid once the window
// pixel that completes it has passed the line memory read, tap, filter and output registers in turn.
// Line memories are indexed by column and read-modified-written once per item.
// Reset (rst, synchronous) clears counters, phase latch and valid bits.
// A stalled output freezes the whole pipeline; s_tready is low only then.
module luma_quarter_pel_interpolator import lqp_pkg::*; #(
  parameter int MAX_BLOCK = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // window_pixel, frac_x, frac_y, block_w, block_h, zero fill
  input  logic        s_tuser,  // block_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // pred_pixel
  output logic        m_tlast
);

  logic     en;
  tap_bus_t taps;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  lqp_window #(.MAX_BLOCK(MAX_BLOCK)) u_window (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .accept       (s_tvalid && en),
    .window_pixel (s_tdata[7:0]),
    .block_start  (s_tuser),
    .frac_x       (s_tdata[9:8]),
    .frac_y       (s_tdata[11:10]),
    .block_w      (s_tdata[16:12]),
    .block_h      (s_tdata[21:17]),
    .taps         (taps)
  );

  lqp_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .taps       (taps),
    .out_valid  (m_tvalid),
    .pred_pixel (m_tdata),
    .block_end  (m_tlast)
  );

endmodule

### rtl/lqp_checker.sv
// Port-level checks for the interpolator, bound to the top level.
module lqp_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

endmodule

bind luma_quarter_pel_interpolator lqp_port_checks u_lqp_port_checks (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
